[hdl/tvbb_pkg.sv]
// ----------------------------------------------------------------------------
// tvbb_pkg: shared types and constants of the transformed vertex bounding box
// Field widths, register indexes, reset values and the structs that pass
// between the configuration, transform and corner tracking units.
// ----------------------------------------------------------------------------
package tvbb_pkg;

    // Default parameter values
    localparam int VERTEX_WIDTH_DEF    = 24;
    localparam int COEFF_FRAC_BITS_DEF = 12;

    // Fixed field widths
    localparam int COORD_W     = 32;
    localparam int COEFF_W     = 16;
    localparam int ROW_W       = 3 * COEFF_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = ROW_W;
    localparam int AXES        = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Z = 3'd5;

    // Reset values: linear part that swaps x and z, zero translation
    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h0000_0000_1000;

    // Saturation limits and empty corner values
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Transform registers as seen by the datapath
    typedef struct packed {
        logic [ROW_W-1:0]          row_x;
        logic [ROW_W-1:0]          row_y;
        logic [ROW_W-1:0]          row_z;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [COORD_W-1:0] shift_z;
    } tvbb_cfg_t;

    // Item flags carried down the transform pipeline
    typedef struct packed {
        logic last_vertex;
        logic empty_mesh;
    } tvbb_flags_t;

    // One transformed vertex with its flags
    typedef struct packed {
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
        logic signed [COORD_W-1:0] wz;
        tvbb_flags_t               flags;
    } tvbb_world_t;

    // Result box; min_x sits in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] box_max_z;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_x;
    } tvbb_box_t;

endpackage

[hdl/transformed_vertex_bounding_box.sv]
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box: world-space AABB of a streamed mesh
// Transforms each vertex by a 3x3 Q3.12 matrix plus Q23.8 translation and
// tracks the axis-aligned bounding box, emitting one box per mesh.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter on the s_axis channel, one beat each; tlast marks the last
//   vertex of a mesh, tuser marks an empty mesh (coordinates ignored, the
//   translation is emitted as both corners). One box leaves on m_axis for
//   each last or empty beat; other beats produce nothing.
//   The transform registers are written over the cfg channel by index; write
//   them only while no mesh is in flight.
//   A box is presented once its closing beat has passed the input register,
//   product register, world register and result register. Throughput: one
//   vertex per cycle while no closing beat waits on a held result, set by
//   the three-stage transform pipeline and the corner update.
//   While m_axis_tready is low the result holds; plain vertices keep flowing
//   into the corners, and the pipeline fills before s_axis_tready drops.
//   Reset clears the pipeline, loads a matrix that swaps x and z with zero
//   translation, and sets the corners to their empty values.
// ----------------------------------------------------------------------------
module transformed_vertex_bounding_box
#(
    parameter int  VERTEX_WIDTH    = tvbb_pkg::VERTEX_WIDTH_DEF,
    parameter int  COEFF_FRAC_BITS = tvbb_pkg::COEFF_FRAC_BITS_DEF,
    localparam int IN_TDATA_W      = ((3 * VERTEX_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W     = 6 * tvbb_pkg::COORD_W
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Vertex stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,  // vert_x, vert_y, vert_z, zero pad
    input  logic                               s_axis_tlast,  // last_vertex
    input  logic                               s_axis_tuser,  // empty_mesh
    // Box stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata,  // box_min_x, box_min_y, box_min_z,
                                                              // box_max_x, box_max_y, box_max_z
    // Register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tvbb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tvbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tvbb_pkg::tvbb_cfg_t   cfg;
    tvbb_pkg::tvbb_flags_t in_flags;
    tvbb_pkg::tvbb_world_t world;
    tvbb_pkg::tvbb_box_t   box;
    logic                  world_valid;
    logic                  world_ready;

    assign in_flags.last_vertex = s_axis_tlast;
    assign in_flags.empty_mesh  = s_axis_tuser;
    assign m_axis_tdata         = box;

    // Transform registers
    tvbb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Vertex transform pipeline
    tvbb_xform
    #(
        .VERTEX_WIDTH    (VERTEX_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    )
    u_xform
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_vert_x (s_axis_tdata[0 +: VERTEX_WIDTH]),
        .in_vert_y (s_axis_tdata[VERTEX_WIDTH +: VERTEX_WIDTH]),
        .in_vert_z (s_axis_tdata[2*VERTEX_WIDTH +: VERTEX_WIDTH]),
        .in_flags  (in_flags),
        .out_valid (world_valid),
        .out_ready (world_ready),
        .out_item  (world)
    );

    // Running corners and result register
    tvbb_corners u_corners
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (world_valid),
        .in_ready  (world_ready),
        .in_item   (world),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_box   (box)
    );

endmodule

[hdl/tvbb_cfg.sv]
// ----------------------------------------------------------------------------
// tvbb_cfg: transform register file
// Holds the three coefficient rows and the translation, written by index
// over the configuration channel. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module tvbb_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tvbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tvbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tvbb_pkg::tvbb_cfg_t                 cfg
);

    tvbb_pkg::tvbb_cfg_t cfg_reg;
    tvbb_pkg::tvbb_cfg_t cfg_next;

    // Always take a write beat
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tvbb_pkg::REG_ROW_X:   cfg_next.row_x   = cfg_data;
                tvbb_pkg::REG_ROW_Y:   cfg_next.row_y   = cfg_data;
                tvbb_pkg::REG_ROW_Z:   cfg_next.row_z   = cfg_data;
                tvbb_pkg::REG_SHIFT_X: cfg_next.shift_x = cfg_data[tvbb_pkg::COORD_W-1:0];
                tvbb_pkg::REG_SHIFT_Y: cfg_next.shift_y = cfg_data[tvbb_pkg::COORD_W-1:0];
                tvbb_pkg::REG_SHIFT_Z: cfg_next.shift_z = cfg_data[tvbb_pkg::COORD_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_x   <= tvbb_pkg::ROW_X_RESET;
            cfg_reg.row_y   <= tvbb_pkg::ROW_Y_RESET;
            cfg_reg.row_z   <= tvbb_pkg::ROW_Z_RESET;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.shift_z <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/tvbb_xform.sv]
// ----------------------------------------------------------------------------
// tvbb_xform: affine vertex transform pipeline
// Three stages: input register, nine registered products, then row sums with
// round-half-up, translation and saturation to Q23.8. Each stage advances
// independently, so bubbles collapse and a full pipe stalls only at its end.
// ----------------------------------------------------------------------------
module tvbb_xform
#(
    parameter int VERTEX_WIDTH    = tvbb_pkg::VERTEX_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = tvbb_pkg::COEFF_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tvbb_pkg::tvbb_cfg_t            cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [VERTEX_WIDTH-1:0] in_vert_x,
    input  logic signed [VERTEX_WIDTH-1:0] in_vert_y,
    input  logic signed [VERTEX_WIDTH-1:0] in_vert_z,
    input  tvbb_pkg::tvbb_flags_t          in_flags,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tvbb_pkg::tvbb_world_t          out_item
);

    localparam int COORD_W = tvbb_pkg::COORD_W;
    localparam int COEFF_W = tvbb_pkg::COEFF_W;
    localparam int AXES    = tvbb_pkg::AXES;
    localparam int PROD_W  = VERTEX_WIDTH + COEFF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHR_W   = SUM_W - COEFF_FRAC_BITS;
    localparam int WIDE_W  = ((SHR_W > COORD_W) ? SHR_W : COORD_W) + 1;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEFF_FRAC_BITS - 1);

    // Stage 0: input register
    logic                           v0_reg;
    logic signed [VERTEX_WIDTH-1:0] vert0_reg [AXES];
    tvbb_pkg::tvbb_flags_t          flags0_reg;

    // Stage 1: products
    logic                           v1_reg;
    logic signed [PROD_W-1:0]       prod_reg  [AXES][AXES];
    logic signed [PROD_W-1:0]       prod_next [AXES][AXES];
    tvbb_pkg::tvbb_flags_t          flags1_reg;

    // Stage 2: world coordinates
    logic                           v2_reg;
    tvbb_pkg::tvbb_world_t          item2_reg;
    tvbb_pkg::tvbb_world_t          item2_next;

    logic                           adv0;
    logic                           adv1;
    logic                           adv2;

    logic [tvbb_pkg::ROW_W-1:0]     row_c   [AXES];
    logic signed [COEFF_W-1:0]      coeff_c [AXES][AXES];
    logic signed [COORD_W-1:0]      shift_c [AXES];
    logic [SUM_W-1:0]               sum_c   [AXES];
    logic [SHR_W-1:0]               shr_c   [AXES];
    logic [WIDE_W-1:0]              wide_c  [AXES];
    logic signed [COORD_W-1:0]      world_c [AXES];

    // Stage advance: a stage loads when it is empty or its content moves on
    assign adv2      = !v2_reg || out_ready;
    assign adv1      = !v1_reg || adv2;
    assign adv0      = !v0_reg || adv1;
    assign in_ready  = adv0;
    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

    // Unpack coefficient rows and translation
    assign row_c[0]   = cfg.row_x;
    assign row_c[1]   = cfg.row_y;
    assign row_c[2]   = cfg.row_z;
    assign shift_c[0] = cfg.shift_x;
    assign shift_c[1] = cfg.shift_y;
    assign shift_c[2] = cfg.shift_z;

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                coeff_c[r][c] = row_c[r][c*COEFF_W +: COEFF_W];
            end
        end
    end

    // Nine independent products
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                prod_next[r][c] = PROD_W'(vert0_reg[c]) * PROD_W'(coeff_c[r][c]);
            end
        end
    end

    // Row sum, round half up, translate, saturate
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            sum_c[r] = {{2{prod_reg[r][0][PROD_W-1]}}, prod_reg[r][0]}
                     + {{2{prod_reg[r][1][PROD_W-1]}}, prod_reg[r][1]}
                     + {{2{prod_reg[r][2][PROD_W-1]}}, prod_reg[r][2]}
                     + ROUND_HALF;
            shr_c[r] = sum_c[r][SUM_W-1:COEFF_FRAC_BITS];
            wide_c[r] = {{(WIDE_W-SHR_W){shr_c[r][SHR_W-1]}}, shr_c[r]}
                      + {{(WIDE_W-COORD_W){shift_c[r][COORD_W-1]}}, shift_c[r]};
            if ((&wide_c[r][WIDE_W-1:COORD_W-1]) || !(|wide_c[r][WIDE_W-1:COORD_W-1]))
            begin
                world_c[r] = wide_c[r][COORD_W-1:0];
            end
            else if (wide_c[r][WIDE_W-1])
            begin
                world_c[r] = tvbb_pkg::COORD_MIN;
            end
            else
            begin
                world_c[r] = tvbb_pkg::COORD_MAX;
            end
        end
        item2_next.wx    = world_c[0];
        item2_next.wy    = world_c[1];
        item2_next.wz    = world_c[2];
        item2_next.flags = flags1_reg;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= in_valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            vert0_reg[0] <= in_vert_x;
            vert0_reg[1] <= in_vert_y;
            vert0_reg[2] <= in_vert_z;
            flags0_reg   <= in_flags;
        end
        if (adv1)
        begin
            prod_reg   <= prod_next;
            flags1_reg <= flags0_reg;
        end
        if (adv2)
        begin
            item2_reg <= item2_next;
        end
    end

    // A stalled transformed vertex stays put
    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !out_ready |=> v2_reg && $stable(item2_reg))
        else $error("transform output changed while stalled");

endmodule

[hdl/tvbb_corners.sv]
// ----------------------------------------------------------------------------
// tvbb_corners: running box corners and result register
// Folds each transformed vertex into the low and high corners. On the last
// vertex or an empty mesh it loads the result register and clears the
// corners. A plain vertex never waits on the result register.
// ----------------------------------------------------------------------------
module tvbb_corners
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tvbb_pkg::tvbb_cfg_t   cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tvbb_pkg::tvbb_world_t in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tvbb_pkg::tvbb_box_t   out_box
);

    localparam int COORD_W = tvbb_pkg::COORD_W;
    localparam int AXES    = tvbb_pkg::AXES;

    logic signed [COORD_W-1:0] low_reg   [AXES];
    logic signed [COORD_W-1:0] high_reg  [AXES];
    logic signed [COORD_W-1:0] low_next  [AXES];
    logic signed [COORD_W-1:0] high_next [AXES];
    logic signed [COORD_W-1:0] w_c       [AXES];
    logic signed [COORD_W-1:0] lo_c      [AXES];
    logic signed [COORD_W-1:0] hi_c      [AXES];

    logic                      out_valid_reg;
    logic                      out_valid_next;
    tvbb_pkg::tvbb_box_t       box_reg;
    tvbb_pkg::tvbb_box_t       box_next;

    logic                      emits;
    logic                      out_free;
    logic                      consume;

    assign emits     = in_item.flags.last_vertex || in_item.flags.empty_mesh;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !emits || out_free;
    assign consume   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_box   = box_reg;

    assign w_c[0] = in_item.wx;
    assign w_c[1] = in_item.wy;
    assign w_c[2] = in_item.wz;

    // Corners including this vertex
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            lo_c[a] = (w_c[a] < low_reg[a])  ? w_c[a] : low_reg[a];
            hi_c[a] = (w_c[a] > high_reg[a]) ? w_c[a] : high_reg[a];
        end
    end

    // Update corners and result register
    always_comb
    begin
        low_next       = low_reg;
        high_next      = high_reg;
        box_next       = box_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (consume)
        begin
            if (in_item.flags.empty_mesh)
            begin
                box_next.box_min_x = cfg.shift_x;
                box_next.box_min_y = cfg.shift_y;
                box_next.box_min_z = cfg.shift_z;
                box_next.box_max_x = cfg.shift_x;
                box_next.box_max_y = cfg.shift_y;
                box_next.box_max_z = cfg.shift_z;
            end
            else
            begin
                box_next.box_min_x = lo_c[0];
                box_next.box_min_y = lo_c[1];
                box_next.box_min_z = lo_c[2];
                box_next.box_max_x = hi_c[0];
                box_next.box_max_y = hi_c[1];
                box_next.box_max_z = hi_c[2];
            end
            if (emits)
            begin
                out_valid_next = 1'b1;
                for (int a = 0; a < AXES; a++)
                begin
                    low_next[a]  = tvbb_pkg::COORD_MAX;
                    high_next[a] = tvbb_pkg::COORD_MIN;
                end
            end
            else
            begin
                box_next  = box_reg;
                low_next  = lo_c;
                high_next = hi_c;
            end
        end
    end

    // Hold corners and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                low_reg[a]  <= tvbb_pkg::COORD_MAX;
                high_reg[a] <= tvbb_pkg::COORD_MIN;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    // Corners clear after every emitted box
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        consume && emits |=>
            low_reg[0] == tvbb_pkg::COORD_MAX && high_reg[0] == tvbb_pkg::COORD_MIN &&
            low_reg[1] == tvbb_pkg::COORD_MAX && high_reg[1] == tvbb_pkg::COORD_MIN &&
            low_reg[2] == tvbb_pkg::COORD_MAX && high_reg[2] == tvbb_pkg::COORD_MIN)
        else $error("corners not cleared after box");

    // A folded vertex leaves an ordered box
    a_ordered_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !emits |=>
            low_reg[0] <= high_reg[0] && low_reg[1] <= high_reg[1] &&
            low_reg[2] <= high_reg[2])
        else $error("corners out of order after vertex");

    // Every emitted box is ordered on each axis
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            box_reg.box_min_x <= box_reg.box_max_x &&
            box_reg.box_min_y <= box_reg.box_max_y &&
            box_reg.box_min_z <= box_reg.box_max_z)
        else $error("emitted box has min above max");

endmodule
